// ===== src/qrs_pkg.sv =====
// types and constants shared by the quadratic root solver
package qrs_pkg;

    localparam int W = 32;
    localparam int F = 16;
    localparam int DW = 2 * W + 2;
    localparam int SW = W + 1;
    localparam int NW = W + 1 + F;
    localparam int MW = W + 1;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_ALL  = 3'd1,
        KIND_ONE  = 3'd2,
        KIND_TWO  = 3'd3,
        KIND_CPLX = 3'd4
    } kind_t;

    typedef struct packed {
        logic signed [W-1:0] coef_a;
        logic signed [W-1:0] coef_b;
        logic signed [W-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        logic [2:0]          solution_kind;
        logic signed [W-1:0] first_real;
        logic signed [W-1:0] first_imag;
        logic signed [W-1:0] second_real;
        logic signed [W-1:0] second_imag;
        logic                overflow;
    } root_t;

    // item context carried down the chain
    typedef struct packed {
        kind_t               kind;
        logic signed [W:0]   nb;
        logic signed [W+1:0] a2;
        logic [DW-1:0]       dmag;
    } ctx_t;

    // one division lane: sign, numerator magnitude, quotient, remainder
    typedef struct packed {
        logic          neg;
        logic [NW-1:0] num;
        logic [NW-1:0] q;
        logic [MW:0]   rem;
    } lane_t;

endpackage

// ===== src/qrs_sqrt_cell.sv =====
// one cell of the square root chain: resolves one root bit per stage
module qrs_sqrt_cell import qrs_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_vld,
    input  ctx_t           in_ctx,
    input  logic [SW-1:0]  in_root,
    output logic           out_vld,
    output ctx_t           out_ctx,
    output logic [SW-1:0]  out_root
);
    logic          vld_reg;
    ctx_t          ctx_reg;
    logic [SW-1:0] root_reg;
    logic [SW-1:0] trial;
    logic [2*SW-1:0] sq;

    always_comb begin
        trial = in_root | (SW'(1) << BIT);
        sq    = trial * trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg  <= in_ctx;
            root_reg <= ((2*SW)'(in_ctx.dmag) >= sq) ? trial : in_root;
        end
    end

    assign out_vld  = vld_reg;
    assign out_ctx  = ctx_reg;
    assign out_root = root_reg;
endmodule

// ===== src/qrs_div_cell.sv =====
// one cell of the division chain: one quotient bit for each of four lanes
module qrs_div_cell import qrs_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_vld,
    input  ctx_t         in_ctx,
    input  logic [MW-1:0] in_den,
    input  lane_t [3:0]  in_lane,
    output logic         out_vld,
    output ctx_t         out_ctx,
    output logic [MW-1:0] out_den,
    output lane_t [3:0]  out_lane
);
    logic          vld_reg;
    ctx_t          ctx_reg;
    logic [MW-1:0] den_reg;
    lane_t [3:0]   lane_reg;
    lane_t [3:0]   lane_next;
    logic [MW:0]   sh;

    always_comb begin
        sh = '0;
        for (int i = 0; i < 4; i++) begin
            lane_next[i] = in_lane[i];
            sh = {in_lane[i].rem[MW-1:0], in_lane[i].num[BIT]};
            if (sh >= {1'b0, in_den}) begin
                lane_next[i].rem    = sh - {1'b0, in_den};
                lane_next[i].q[BIT] = 1'b1;
            end else begin
                lane_next[i].rem = sh;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg  <= in_ctx;
            den_reg  <= in_den;
            lane_reg <= lane_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_ctx  = ctx_reg;
    assign out_den  = den_reg;
    assign out_lane = lane_reg;
endmodule

// ===== src/quadratic_root_solver_core.sv =====
// quadratic root solver top level: front end, sqrt and divide cell chains, output stage
//
// s_ channel takes one coefficient set (a, b, c, signed Q16.16) per transaction;
// m_ channel returns one result per input: solution kind, two complex roots and
// an overflow flag. cfg_ channel writes zero_tolerance; the user must write it only while
// the block is idle, as the block itself does not enforce this. the block is a linear
// pipeline: two front-end stages form |b|^2, 4|a||c| and the discriminant, a chain of 33
// square root cells resolves one root bit each, a chain of 49 divide cells produces one
// quotient bit each for four roots in parallel, and one output stage saturates and registers
// the result. throughput is one coefficient set per cycle while the output is not stalled.
// the whole chain advances only while the output register is empty or being taken,
// so a stalled receiver freezes every stage and s_ready drops with it; nothing is lost.
// reset (aresetn low, synchronous) clears all valid bits and zero_tolerance.
module quadratic_root_solver_core import qrs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  coef_t       s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output root_t       m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    localparam int NDIV = NW;

    logic [15:0] tol_reg;
    logic        en;
    logic        out_vld_reg;
    root_t       out_reg;

    assign en        = !out_vld_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    // stage 1: magnitudes and products
    logic          v1_reg;
    kind_t         k1_reg;
    logic          lin1_reg;
    logic          signs_differ1_reg;
    logic signed [W:0]   nb1_reg, nc1_reg;
    logic signed [W+1:0] a21_reg;
    logic [2*W-1:0] b2_reg, ac_reg;
    logic [W:0]    ma, mb, mc;
    logic          az, bz, cz;

    always_comb begin
        ma = s_data.coef_a[W-1] ? -{1'b1, s_data.coef_a} : {1'b0, s_data.coef_a};
        mb = s_data.coef_b[W-1] ? -{1'b1, s_data.coef_b} : {1'b0, s_data.coef_b};
        mc = s_data.coef_c[W-1] ? -{1'b1, s_data.coef_c} : {1'b0, s_data.coef_c};
        az = ma <= (W+1)'(tol_reg);
        bz = mb <= (W+1)'(tol_reg);
        cz = mc <= (W+1)'(tol_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lin1_reg <= az;
            if (az && bz) begin
                k1_reg <= cz ? KIND_ALL : KIND_NONE;
            end else begin
                k1_reg <= KIND_ONE;
            end
            // linear case: quotient -c/b, carried in nb (numerator) and a2 (denominator)
            nb1_reg <= -(W+1)'(s_data.coef_b);
            nc1_reg <= -(W+1)'(s_data.coef_c);
            a21_reg <= az ? (W+2)'(s_data.coef_b) : ((W+2)'(s_data.coef_a) <<< 1);
            signs_differ1_reg <= s_data.coef_a[W-1] != s_data.coef_c[W-1];
            b2_reg <= mb[W-1:0] * mb[W-1:0] + ((mb[W] ? (2*W)'(1) << (2*W-2) : '0));
            ac_reg <= ma[W-1:0] * mc[W-1:0] + ((ma[W] ? (2*W)'(mc[W-1:0]) << (W-1) : '0))
                    + ((mc[W] ? (2*W)'(ma[W-1:0]) << (W-1) : '0));
        end
    end

    // stage 2: discriminant and kind
    logic  v2_reg;
    ctx_t  c2_reg;
    logic [DW-1:0] p, bb, dm, tw;
    logic  dneg;

    always_comb begin
        p  = DW'(ac_reg) << 2;
        bb = DW'(b2_reg);
        tw = DW'(tol_reg) << F;
        if (signs_differ1_reg) begin
            dm = bb + p; dneg = 1'b0;
        end else if (bb >= p) begin
            dm = bb - p; dneg = 1'b0;
        end else begin
            dm = p - bb; dneg = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg.a2 <= a21_reg;
            if (lin1_reg) begin
                c2_reg.kind <= k1_reg;
                c2_reg.nb   <= nc1_reg;
                c2_reg.dmag <= '0;
            end else begin
                c2_reg.nb <= nb1_reg;
                if (dm <= tw) begin
                    c2_reg.kind <= KIND_ONE;
                    c2_reg.dmag <= '0;
                end else begin
                    c2_reg.kind <= dneg ? KIND_CPLX : KIND_TWO;
                    c2_reg.dmag <= dm;
                end
            end
        end
    end

    // square root chain
    logic          sv [SW+1];
    ctx_t          sc [SW+1];
    logic [SW-1:0] sr [SW+1];

    assign sv[0] = v2_reg;
    assign sc[0] = c2_reg;
    assign sr[0] = '0;

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        qrs_sqrt_cell #(.BIT(SW-1-g)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_vld(sv[g]), .in_ctx(sc[g]), .in_root(sr[g]),
            .out_vld(sv[g+1]), .out_ctx(sc[g+1]), .out_root(sr[g+1])
        );
    end

    // divider setup: four numerators over 2a (or b in the linear case)
    logic          dv [NDIV+1];
    ctx_t          dc [NDIV+1];
    logic [MW-1:0] dd [NDIV+1];
    lane_t [3:0]   dl [NDIV+1];
    logic signed [W+1:0] nums [4];
    logic signed [W+1:0] s_ext;
    logic [W+1:0]  nmag;

    always_comb begin
        s_ext   = (W+2)'(sr[SW]);
        nums[0] = (W+2)'(sc[SW].nb);
        nums[1] = (W+2)'(sc[SW].nb);
        nums[2] = '0;
        nums[3] = '0;
        if (sc[SW].kind == KIND_TWO) begin
            nums[0] = (W+2)'(sc[SW].nb) + s_ext;
            nums[1] = (W+2)'(sc[SW].nb) - s_ext;
        end else if (sc[SW].kind == KIND_CPLX) begin
            nums[2] = s_ext;
            nums[3] = -s_ext;
        end
        dd[0] = sc[SW].a2[W+1] ? MW'(-sc[SW].a2) : MW'(sc[SW].a2);
        for (int i = 0; i < 4; i++) begin
            nmag = nums[i][W+1] ? -nums[i] : nums[i];
            dl[0][i].neg = (nums[i][W+1] != sc[SW].a2[W+1]) && (nums[i] != 0);
            dl[0][i].num = NW'(nmag) << F;
            dl[0][i].q   = '0;
            dl[0][i].rem = '0;
        end
    end

    assign dv[0] = sv[SW];
    assign dc[0] = sc[SW];

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        qrs_div_cell #(.BIT(NDIV-1-g)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_vld(dv[g]), .in_ctx(dc[g]), .in_den(dd[g]), .in_lane(dl[g]),
            .out_vld(dv[g+1]), .out_ctx(dc[g+1]), .out_den(dd[g+1]), .out_lane(dl[g+1])
        );
    end

    // saturation and output register
    logic [W-1:0] rv [4];
    logic [3:0]   ov;
    logic [NW-1:0] lim;
    root_t        res;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lim = dl[NDIV][i].neg ? (NW'(1) << (W-1)) : ((NW'(1) << (W-1)) - NW'(1));
            if (dl[NDIV][i].q > lim) begin
                ov[i] = 1'b1;
                rv[i] = dl[NDIV][i].neg ? W'(-lim) : W'(lim);
            end else begin
                ov[i] = 1'b0;
                rv[i] = dl[NDIV][i].neg ? W'(-dl[NDIV][i].q) : W'(dl[NDIV][i].q);
            end
        end
        res = '0;
        res.solution_kind = dc[NDIV].kind;
        case (dc[NDIV].kind)
            KIND_ONE: begin
                res.first_real = rv[1];
                res.overflow   = ov[1];
            end
            KIND_TWO: begin
                res.first_real  = rv[0];
                res.second_real = rv[1];
                res.overflow    = ov[0] | ov[1];
            end
            KIND_CPLX: begin
                res.first_real  = rv[0];
                res.second_real = rv[0];
                res.first_imag  = rv[2];
                res.second_imag = rv[3];
                res.overflow    = ov[0] | ov[2] | ov[3];
            end
            default: begin
                res = '0;
                res.solution_kind = dc[NDIV].kind;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.solution_kind <= KIND_CPLX)
        else $error("bad solution kind");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during stall");
endmodule

// ===== dv/tb_quadratic_root_solver_core.sv =====
// testbench for the quadratic root solver core: directed and random traffic checked against a predictor
module tb_quadratic_root_solver_core import qrs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_STALL = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    coef_t       s_data;
    logic        m_valid;
    logic        m_ready;
    root_t       m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    coef_t pending_coefs[$];
    root_t expected_roots[$];
    logic [15:0] tol_shadow;
    int  mismatches;
    int  idle_cycles;
    bit  s_fire;
    int  send_gap;
    int  recv_gap;
    int  stall_left;
    int  stall_ask;
    int  stall_seen;
    bit  no_gaps;
    bit  sender_hold;

    quadratic_root_solver_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // truncating fixed-point divide with saturation to the word range
    function automatic logic [31:0] fx_div(longint num, longint den, inout bit ovf);
        bit neg;
        logic [127:0] q;
        logic [127:0] lim;
        neg = (num < 0) != (den < 0);
        q = ({64'd0, mag64(num)} << F) / {64'd0, mag64(den)};
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            q = lim;
            ovf = 1'b1;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic root_t solve_roots(coef_t cf, logic [15:0] tol);
        root_t res;
        longint a;
        longint b;
        longint c;
        longint s;
        logic [127:0] b2;
        logic [127:0] p4;
        logic [127:0] dmag;
        bit dneg;
        bit ovf;
        a = cf.coef_a;
        b = cf.coef_b;
        c = cf.coef_c;
        res = '0;
        ovf = 1'b0;
        dneg = 1'b0;
        if (mag64(a) <= tol) begin
            if (mag64(b) <= tol) begin
                res.solution_kind = (mag64(c) <= tol) ? KIND_ALL : KIND_NONE;
            end else begin
                res.solution_kind = KIND_ONE;
                res.first_real = fx_div(-c, b, ovf);
            end
        end else begin
            b2 = mag64(b) * mag64(b);
            p4 = (128'(mag64(a)) * mag64(c)) << 2;
            if ((a < 0) != (c < 0)) begin
                dmag = b2 + p4;
            end else if (b2 >= p4) begin
                dmag = b2 - p4;
            end else begin
                dmag = p4 - b2;
                dneg = 1'b1;
            end
            if (dmag <= (128'(tol) << F)) begin
                res.solution_kind = KIND_ONE;
                res.first_real = fx_div(-b, 2 * a, ovf);
            end else if (!dneg) begin
                s = longint'(isqrt(dmag));
                res.solution_kind = KIND_TWO;
                res.first_real = fx_div(-b + s, 2 * a, ovf);
                res.second_real = fx_div(-b - s, 2 * a, ovf);
            end else begin
                s = longint'(isqrt(dmag));
                res.solution_kind = KIND_CPLX;
                res.first_real = fx_div(-b, 2 * a, ovf);
                res.second_real = res.first_real;
                res.first_imag = fx_div(s, 2 * a, ovf);
                res.second_imag = fx_div(-s, 2 * a, ovf);
            end
        end
        res.overflow = ovf;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [31:0] small_q(int span);
        return 32'(($urandom_range(2 * span) - span)) << F;
    endfunction

    // one random coefficient set: fully random, small, linear, known integer roots or complex pair
    function automatic coef_t random_coefs(logic [15:0] tol);
        coef_t cf;
        int r1;
        int r2;
        int ak;
        case ($urandom_range(5))
            0: begin
                cf.coef_a = $urandom;
                cf.coef_b = $urandom;
                cf.coef_c = $urandom;
            end
            1: begin
                cf.coef_a = small_q(20);
                cf.coef_b = small_q(20);
                cf.coef_c = small_q(20);
            end
            2: begin
                // linear or degenerate: a inside the tolerance band
                cf.coef_a = 32'($urandom_range(2 * tol) - tol);
                cf.coef_b = ($urandom_range(3) == 0) ? 32'($urandom_range(2 * tol) - tol)
                                                     : $urandom;
                cf.coef_c = ($urandom_range(3) == 0) ? 32'($urandom_range(2 * tol) - tol)
                                                     : $urandom;
            end
            3: begin
                r1 = $urandom_range(30) - 15;
                r2 = ($urandom_range(3) == 0) ? r1 : $urandom_range(30) - 15;
                ak = $urandom_range(8) - 4;
                if (ak == 0) ak = 1;
                cf.coef_a = 32'(ak) << F;
                cf.coef_b = 32'(-ak * (r1 + r2)) << F;
                cf.coef_c = 32'(ak * r1 * r2) << F;
            end
            4: begin
                cf.coef_a = 32'($urandom_range(2 ** 21) - 2 ** 20);
                cf.coef_b = 32'($urandom_range(2 ** 21) - 2 ** 20);
                cf.coef_c = 32'($urandom_range(2 ** 21) - 2 ** 20);
            end
            default: begin
                // usually a complex pair: same sign a and c, small b
                ak = $urandom_range(1, 9);
                cf.coef_a = 32'(ak) << F;
                cf.coef_b = small_q(3);
                cf.coef_c = 32'(ak * $urandom_range(2, 50)) << F;
                if ($urandom_range(1)) begin
                    cf.coef_a = -cf.coef_a;
                    cf.coef_c = -cf.coef_c;
                end
            end
        endcase
        return cf;
    endfunction

    function automatic coef_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        coef_t cf;
        cf.coef_a = a;
        cf.coef_b = b;
        cf.coef_c = c;
        return cf;
    endfunction

    // accept side: predictions, checks, config shadow, watchdog
    always @(posedge aclk) begin
        root_t want;
        s_fire = s_valid && s_ready && aresetn;
        if (s_fire) begin
            expected_roots.push_back(solve_roots(pending_coefs.pop_front(), tol_shadow));
        end
        if (cfg_valid && cfg_ready && aresetn) tol_shadow = cfg_data;
        if (m_valid && m_ready && aresetn) begin
            if (expected_roots.size() == 0) begin
                $display("unexpected result transaction");
                mismatches++;
            end else begin
                want = expected_roots.pop_front();
                if (m_data.solution_kind !== want.solution_kind)
                    report_mismatch("solution_kind", m_data.solution_kind,
                                    want.solution_kind);
                if (m_data.first_real !== want.first_real)
                    report_mismatch("first_real", m_data.first_real, want.first_real);
                if (m_data.first_imag !== want.first_imag)
                    report_mismatch("first_imag", m_data.first_imag, want.first_imag);
                if (m_data.second_real !== want.second_real)
                    report_mismatch("second_real", m_data.second_real, want.second_real);
                if (m_data.second_imag !== want.second_imag)
                    report_mismatch("second_imag", m_data.second_imag, want.second_imag);
                if (m_data.overflow !== want.overflow)
                    report_mismatch("overflow", m_data.overflow, want.overflow);
            end
        end
        if (s_fire || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_coefs.size() > 0 && !sender_hold) begin
                s_valid <= 1'b1;
                s_data <= pending_coefs[0];
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with an occasional long hold-off
    always @(negedge aclk) begin
        if (stall_seen != stall_ask) begin
            stall_seen = stall_ask;
            stall_left = LONG_STALL;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    task automatic write_tolerance(logic [15:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_coefs.size() == 0 && expected_roots.size() == 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) pending_coefs.push_back(random_coefs(tol_shadow));
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        tol_shadow = '0;
        mismatches = 0;
        idle_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        stall_left = 0;
        stall_ask = 0;
        stall_seen = 0;
        no_gaps = 1'b0;
        sender_hold = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_tolerance(16'd0);
        // directed: degenerate, linear, double, real, complex, extremes
        pending_coefs.push_back(mk(32'h0, 32'h0, 32'h0));
        pending_coefs.push_back(mk(32'h0, 32'h0, 32'h0001_0000));
        pending_coefs.push_back(mk(32'h0, 32'h0002_0000, 32'hfffc_0000));
        pending_coefs.push_back(mk(32'h0, 32'h0000_0001, 32'h7fff_ffff));
        pending_coefs.push_back(mk(32'h0, 32'h8000_0000, 32'h8000_0000));
        pending_coefs.push_back(mk(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000));
        pending_coefs.push_back(mk(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000));
        pending_coefs.push_back(mk(32'h0001_0000, 32'h0, 32'h0001_0000));
        pending_coefs.push_back(mk(32'hffff_0000, 32'h0, 32'hffff_0000));
        pending_coefs.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_coefs.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_coefs.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_coefs.push_back(mk(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000));
        pending_coefs.push_back(mk(32'h0000_0001, 32'h0, 32'h7fff_ffff));
        pending_coefs.push_back(mk(32'hffff_ffff, 32'h8000_0000, 32'h0));
        pending_coefs.push_back(mk(32'h0001_0000, 32'h0, 32'h0));
        pending_coefs.push_back(mk(32'h0000_0001, 32'h0000_0002, 32'h0000_0001));
        queue_random(380);
        drain();

        // wide tolerance; long receiver stall while the sender keeps offering
        write_tolerance(16'hffff);
        pending_coefs.push_back(mk(32'h0000_ffff, 32'h0000_ffff, 32'h0000_ffff));
        pending_coefs.push_back(mk(32'h0001_0000, 32'h0000_ffff, 32'h0));
        pending_coefs.push_back(mk(32'h0001_0000, 32'h0002_0000, 32'h0000_ffff));
        queue_random(200);
        repeat (50) @(posedge aclk);
        stall_ask++;
        queue_random(200);
        drain();

        // sender holds mid-stream until every result is back, then resumes
        write_tolerance(16'($urandom_range(1, 65534)));
        queue_random(300);
        wait (pending_coefs.size() <= 200);
        sender_hold = 1'b1;
        wait (expected_roots.size() == 0);
        repeat (20) @(posedge aclk);
        sender_hold = 1'b0;
        queue_random(100);
        drain();

        // small tolerance, first back to back without gaps, then with gaps again
        write_tolerance(16'd3);
        no_gaps = 1'b1;
        queue_random(200);
        wait (pending_coefs.size() == 0);
        no_gaps = 1'b0;
        queue_random(200);
        drain();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/qrs_pkg.sv
src/qrs_sqrt_cell.sv
src/qrs_div_cell.sv
src/quadratic_root_solver_core.sv
dv/tb_quadratic_root_solver_core.sv
